// File: rtl/core/sllr_pkg.sv
`default_nettype none

package sllr_pkg;

  // default sizes of the time log and the destination rotation
  localparam int unsigned LogDepthDefault = 1024;
  localparam int unsigned MaxDestDefault  = 16;

  // field widths
  localparam int unsigned TimeW  = 48;
  localparam int unsigned MaxW   = 11;
  localparam int unsigned WinW   = 32;
  localparam int unsigned NdestW = 5;
  localparam int unsigned DestW  = 4;
  localparam int unsigned CountW = 11;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_PER_WINDOW   = 2'd0,
    CFG_WINDOW_US        = 2'd1,
    CFG_NUM_DESTINATIONS = 2'd2
  } cfg_idx_e;

  // register reset values
  localparam logic [MaxW-1:0]   MaxPerWindowRst    = 11'd1024;
  localparam logic [WinW-1:0]   WindowUsRst        = 32'd1000000;
  localparam logic [NdestW-1:0] NumDestinationsRst = 5'd1;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/sllr_ram.sv
`default_nettype none

module sllr_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/sliding_log_rate_limit_round_robin.sv
// Sliding-window log rate limiter with round-robin destination choice. Each
// input word is one packet arrival (time in microseconds, nondecreasing, plus
// the downstream send status); each produces exactly one output word saying
// whether the packet is forwarded, the destination it goes to, and how many
// times remain logged. Logged times sit in a single-port-read RAM of LOG_DEPTH
// entries handled as a FIFO; on an arrival the oldest entries are aged out one
// per cycle through the RAM read port before the packet is decided. The log
// needs no clearing after reset: a fill count marks the live entries.
// Configuration writes are taken at any time (cfg_ready_o is always high) but
// must be made while the block is idle.
`default_nettype none

module sliding_log_rate_limit_round_robin #(
  parameter int unsigned LOG_DEPTH = sllr_pkg::LogDepthDefault,
  parameter int unsigned MAX_DEST  = sllr_pkg::MaxDestDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,  // arrival_time_us[47:0], send_ok[48], zero fill
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o   // forward[0], dest_index[4:1], log_count[15:5]
);

  localparam int unsigned AW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(LOG_DEPTH + 1);
  localparam int unsigned PW  = (MAX_DEST > 1) ? $clog2(MAX_DEST) : 1;
  localparam int unsigned DCW = $clog2(MAX_DEST + 1);
  localparam int unsigned TW  = sllr_pkg::TimeW;

  // configuration registers
  logic [sllr_pkg::MaxW-1:0]   cfg_max_q;
  logic [sllr_pkg::WinW-1:0]   cfg_win_q;
  logic [sllr_pkg::NdestW-1:0] cfg_ndest_q;

  // log pointers and rotation state
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [PW-1:0] dest_q, dest_d;

  // captured arrival
  logic [TW-1:0] now_q;
  logic          ok_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q, out_data_d;

  // ram and write forwarding
  logic          ram_we;
  logic [TW-1:0] ram_rdata;
  logic          fwd_hit_q;
  logic [TW-1:0] fwd_data_q;
  logic [TW-1:0] head_time;

  sllr_pkg::state_e state_q, state_d;

  // control strobes
  logic in_accept;
  logic out_free;
  logic expire;
  logic pop;
  logic finish;

  // decision datapath
  logic [DCW-1:0] n_eff;
  logic [PW-1:0]  cur_dest;
  logic [DCW-1:0] dest_inc;
  logic           fwd;
  logic           log_it;
  logic [31:0]    dest_ext;
  logic [31:0]    fill_ext;
  logic [TW-1:0]  age;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max_q   <= sllr_pkg::MaxPerWindowRst;
      cfg_win_q   <= sllr_pkg::WindowUsRst;
      cfg_ndest_q <= sllr_pkg::NumDestinationsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sllr_pkg::CFG_MAX_PER_WINDOW:   cfg_max_q   <= cfg_data_i[sllr_pkg::MaxW-1:0];
        sllr_pkg::CFG_WINDOW_US:        cfg_win_q   <= cfg_data_i[sllr_pkg::WinW-1:0];
        sllr_pkg::CFG_NUM_DESTINATIONS: cfg_ndest_q <= cfg_data_i[sllr_pkg::NdestW-1:0];
        default: ;
      endcase
    end
  end

  // head entry, with the word written last cycle taking priority
  assign head_time = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign age       = now_q - head_time;
  assign expire    = (fill_q != '0) && (now_q > head_time)
                   && (age > {{(TW - sllr_pkg::WinW){1'b0}}, cfg_win_q});

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sllr_pkg::ST_IDLE: if (s_axis_tvalid_i) state_d = sllr_pkg::ST_SCAN;
      sllr_pkg::ST_SCAN: if (!expire && out_free) state_d = sllr_pkg::ST_IDLE;
      default:           state_d = sllr_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    pop             = 1'b0;
    finish          = 1'b0;
    unique case (state_q)
      sllr_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      sllr_pkg::ST_SCAN: begin
        pop    = expire;
        finish = !expire && out_free;
      end
      default: ;
    endcase
  end

  // effective destination count and current pointer
  always_comb begin
    if (cfg_ndest_q == '0) begin
      n_eff = DCW'(1);
    end else if (32'(cfg_ndest_q) > MAX_DEST) begin
      n_eff = DCW'(MAX_DEST);
    end else begin
      n_eff = DCW'(cfg_ndest_q);
    end
    cur_dest = (DCW'(dest_q) >= n_eff) ? '0 : dest_q;
    dest_inc = DCW'(cur_dest) + DCW'(1);
  end

  assign fwd    = 32'(fill_q) < 32'(cfg_max_q);
  assign log_it = fwd && ok_q && (32'(fill_q) < LOG_DEPTH);
  assign ram_we = finish && log_it;

  // pointer, count and output updates
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    dest_d      = dest_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    dest_ext    = '0;
    fill_ext    = '0;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (pop) begin
      head_d = (32'(head_q) == LOG_DEPTH - 1) ? '0 : head_q + AW'(1);
      fill_d = fill_q - FW'(1);
    end

    if (finish) begin
      if (log_it) begin
        tail_d = (32'(tail_q) == LOG_DEPTH - 1) ? '0 : tail_q + AW'(1);
        fill_d = fill_q + FW'(1);
      end
      if (fwd) begin
        dest_d   = (dest_inc == n_eff) ? '0 : PW'(dest_inc);
        dest_ext = 32'(cur_dest);
      end
      fill_ext    = 32'(fill_d);
      out_valid_d = 1'b1;
      out_data_d  = {fill_ext[sllr_pkg::CountW-1:0], dest_ext[sllr_pkg::DestW-1:0], fwd};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sllr_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      dest_q      <= '0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      dest_q      <= dest_d;
      out_valid_q <= out_valid_d;
      fwd_hit_q   <= ram_we && (tail_q == head_d);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q <= s_axis_tdata_i[TW-1:0];
      ok_q  <= s_axis_tdata_i[TW];
    end
    out_data_q <= out_data_d;
    fwd_data_q <= now_q;
  end

  // time log, read address follows the next head
  sllr_ram #(
    .Width (TW),
    .Depth (LOG_DEPTH)
  ) u_log (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (now_q),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // the log never holds more entries than it has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= LOG_DEPTH)
    else $error("log fill count beyond depth");

  // an accepted word always starts a scan of the log head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == sllr_pkg::ST_SCAN)
    else $error("accepted word did not start a scan");

  // a dropped packet carries destination zero and leaves the count as it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && !fwd) |=> (out_data_q[4:1] == '0) && $stable(fill_q))
    else $error("dropped packet changed destination or log count");

  // popping only happens with a nonempty log
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fill_q != '0)
    else $error("pop from an empty log");

endmodule

`default_nettype wire
